// ===== src/rrt_pkg.sv =====
// Types and constants shared by the request retry tracker.
`default_nettype none

package rrt_pkg;

    localparam int TIME_WIDTH = 64;

    typedef logic [TIME_WIDTH-1:0] time_t;

    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_POLL     = 2'd1,
        OP_RESPONSE = 2'd2,
        OP_CANCEL   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_NOTHING = 3'd0,
        ST_BEGUN   = 3'd1,
        ST_REFUSED = 3'd2,
        ST_RETRY   = 3'd3,
        ST_FAILED  = 3'd4,
        ST_MATCHED = 3'd5
    } status_t;

    typedef struct packed {
        op_t         opcode;
        logic [7:0]  msg_type;
        logic [31:0] txn_id;
        logic [31:0] seq_no;
        logic [15:0] frame_len;
        logic [63:0] now_time;
        logic [63:0] wait_time;
        logic [31:0] retry_limit;
        logic        ack_flag;
        logic [15:0] res_code;
        logic [15:0] det_code;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic        out_ack;
        logic [15:0] out_result;
        logic [15:0] out_detail;
        logic [31:0] retry_txn;
        logic [31:0] retry_seq;
        logic [31:0] retries_done_out;
    } rsp_t;

endpackage

`default_nettype wire

// ===== src/rrt_if.sv =====
// Valid/ready channel interfaces for tracker input items and results.
`default_nettype none

interface rrt_req_if;
    logic          valid;
    logic          ready;
    rrt_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rrt_rsp_if;
    logic          valid;
    logic          ready;
    rrt_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/reliable_request_retry_tracker_core.sv =====
// Stop-and-wait request retry tracker: one outstanding request, timeout and retry.
//
// channel  direction  payload  role
// req      in         req_t    begin / poll / response / cancel items
// rsp      out        rsp_t    one result beat per item
//
// Two-stage path: input register, then state update and result register.
// One item per cycle unless rsp stalls; the result is registered after in_reg.
// The cycle limit is the 64-bit deadline add and compare in the update stage.
// rst_n clears the request state and both valid flags; no warm-up needed.
// A stalled result holds; one more item can sit in the input register meanwhile.
`default_nettype none

module reliable_request_retry_tracker_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rrt_req_if.sink    req,
    rrt_rsp_if.source  rsp
);

    logic          in_valid_reg;
    rrt_pkg::req_t in_reg;
    logic          out_valid_reg;
    rrt_pkg::rsp_t out_reg;

    logic          busy_reg;
    logic [7:0]    held_type_reg;
    logic [31:0]   held_txn_reg;
    logic [31:0]   held_seq_reg;
    rrt_pkg::time_t held_timeout_reg;
    logic [31:0]   held_limit_reg;
    logic [31:0]   retry_count_reg;
    rrt_pkg::time_t deadline_reg;

    logic          busy_next;
    logic [7:0]    held_type_next;
    logic [31:0]   held_txn_next;
    logic [31:0]   held_seq_next;
    rrt_pkg::time_t held_timeout_next;
    logic [31:0]   held_limit_next;
    logic [31:0]   retry_count_next;
    rrt_pkg::time_t deadline_next;
    rrt_pkg::rsp_t out_next;

    logic          advance;
    rrt_pkg::time_t now_t;
    rrt_pkg::time_t wait_t;
    rrt_pkg::time_t sum_t;
    logic          due;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    assign now_t  = in_reg.now_time[rrt_pkg::TIME_WIDTH-1:0];
    assign wait_t = in_reg.wait_time[rrt_pkg::TIME_WIDTH-1:0];
    assign sum_t  = now_t + ((in_reg.opcode == rrt_pkg::OP_BEGIN) ? wait_t : held_timeout_reg);
    assign due    = busy_reg && (now_t >= deadline_reg);

    always_comb
    begin
        busy_next         = busy_reg;
        held_type_next    = held_type_reg;
        held_txn_next     = held_txn_reg;
        held_seq_next     = held_seq_reg;
        held_timeout_next = held_timeout_reg;
        held_limit_next   = held_limit_reg;
        retry_count_next  = retry_count_reg;
        deadline_next     = deadline_reg;
        out_next          = '0;
        out_next.status   = rrt_pkg::ST_NOTHING;

        case (in_reg.opcode)
            rrt_pkg::OP_BEGIN:
            begin
                if (busy_reg || in_reg.frame_len == 16'd0 || wait_t == '0)
                begin
                    out_next.status = rrt_pkg::ST_REFUSED;
                end
                else
                begin
                    busy_next         = 1'b1;
                    held_type_next    = in_reg.msg_type;
                    held_txn_next     = in_reg.txn_id;
                    held_seq_next     = in_reg.seq_no;
                    held_timeout_next = wait_t;
                    held_limit_next   = in_reg.retry_limit;
                    retry_count_next  = 32'd0;
                    deadline_next     = sum_t;
                    out_next.status   = rrt_pkg::ST_BEGUN;
                end
            end
            rrt_pkg::OP_POLL:
            begin
                if (due)
                begin
                    if (retry_count_reg >= held_limit_reg)
                    begin
                        busy_next         = 1'b0;
                        held_type_next    = '0;
                        held_txn_next     = '0;
                        held_seq_next     = '0;
                        held_timeout_next = '0;
                        held_limit_next   = '0;
                        retry_count_next  = '0;
                        deadline_next     = '0;
                        out_next.status   = rrt_pkg::ST_FAILED;
                    end
                    else
                    begin
                        retry_count_next          = retry_count_reg + 32'd1;
                        deadline_next             = sum_t;
                        out_next.status           = rrt_pkg::ST_RETRY;
                        out_next.retry_txn        = held_txn_reg;
                        out_next.retry_seq        = held_seq_reg;
                        out_next.retries_done_out = retry_count_reg + 32'd1;
                    end
                end
            end
            rrt_pkg::OP_RESPONSE:
            begin
                if (busy_reg && in_reg.msg_type == held_type_reg
                    && in_reg.txn_id == held_txn_reg)
                begin
                    out_next.status     = rrt_pkg::ST_MATCHED;
                    out_next.out_ack    = in_reg.ack_flag;
                    out_next.out_result = in_reg.res_code;
                    out_next.out_detail = in_reg.det_code;
                    busy_next           = 1'b0;
                    held_type_next      = '0;
                    held_txn_next       = '0;
                    held_seq_next       = '0;
                    held_timeout_next   = '0;
                    held_limit_next     = '0;
                    retry_count_next    = '0;
                    deadline_next       = '0;
                end
            end
            default:
            begin
                busy_next         = 1'b0;
                held_type_next    = '0;
                held_txn_next     = '0;
                held_seq_next     = '0;
                held_timeout_next = '0;
                held_limit_next   = '0;
                retry_count_next  = '0;
                deadline_next     = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            busy_reg         <= 1'b0;
            held_type_reg    <= '0;
            held_txn_reg     <= '0;
            held_seq_reg     <= '0;
            held_timeout_reg <= '0;
            held_limit_reg   <= '0;
            retry_count_reg  <= '0;
            deadline_reg     <= '0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg    <= 1'b1;
                busy_reg         <= busy_next;
                held_type_reg    <= held_type_next;
                held_txn_reg     <= held_txn_next;
                held_seq_reg     <= held_seq_next;
                held_timeout_reg <= held_timeout_next;
                held_limit_reg   <= held_limit_next;
                retry_count_reg  <= retry_count_next;
                deadline_reg     <= deadline_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg <= req.data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // retries only grow while below the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        retry_count_reg <= held_limit_reg)
        else $error("retry count above limit");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (retry_count_reg == 32'd0 && deadline_reg == '0))
        else $error("idle tracker holds stale state");

    a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_next.status == rrt_pkg::ST_BEGUN) |=> busy_reg)
        else $error("begun request not outstanding");

    a_retry_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status == rrt_pkg::ST_RETRY)
            |-> rsp.data.retries_done_out != 32'd0)
        else $error("retry beat with zero count");

    a_ack_only_match: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.status != rrt_pkg::ST_MATCHED)
            |-> (rsp.data.out_ack == 1'b0 && rsp.data.out_result == 16'd0
                 && rsp.data.out_detail == 16'd0))
        else $error("response codes on unmatched beat");

endmodule

`default_nettype wire
